### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files of the literal encoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/u8lit_pkg.sv
// shared types, constants and helper functions of the literal encoder
package u8lit_pkg;

	// default depth of the job queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	// input item kinds carried on s_tuser
	typedef enum logic [1:0] {
		MODE_START  = 2'd0,
		MODE_DATA   = 2'd1,
		MODE_END    = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	// output character sequences the back end knows how to expand
	typedef enum logic [2:0] {
		KIND_NONE  = 3'd0,
		KIND_CHAR1 = 3'd1,
		KIND_CHAR2 = 3'd2,
		KIND_HEX1  = 3'd3,
		KIND_HEX2  = 3'd4
	} kind_t;

	// one job: optional leading error beat plus a character sequence
	// char1: val[7:0]; char2: val[7:0] then val[15:8]
	// hex1: val[15:0]; hex2: val[19:0] is code point minus 0x10000
	typedef struct packed {
		logic       err;
		kind_t      kind;
		logic [20:0] val;
	} job_t;

	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_L      = 8'h4c;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_R      = 8'h72;

	localparam logic [15:0] SURR_HI = 16'hd800;
	localparam logic [15:0] SURR_LO = 16'hdc00;

	// lowercase hex digit
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		begin
			if (nib < 4'd10) begin
				c = 8'h30 + {4'd0, nib};
			end else begin
				c = 8'h57 + {4'd0, nib};
			end
			return c;
		end
	endfunction

	// number of characters a job kind expands to
	function automatic logic [3:0] kind_chars(input kind_t k);
		logic [3:0] n;
		begin
			case (k)
				KIND_CHAR1: n = 4'd1;
				KIND_CHAR2: n = 4'd2;
				KIND_HEX1:  n = 4'd6;
				KIND_HEX2:  n = 4'd12;
				default:    n = 4'd0;
			endcase
			return n;
		end
	endfunction

endpackage

### hw/rtl/utf8_to_utf16_c_literal_top.sv
// top level of the utf-8 path to c string literal encoder
// path: items pass through the job queue and then the output register
// throughput: one output beat per cycle from the back end while the receiver is
// ready; an item gives 1 to 12 beats (six characters for a control byte when
// transcoding), input beats are taken each cycle while the job queue has room
// reset: decoder state, queue and output valid clear; transcode register resets to 1
module utf8_to_utf16_c_literal_top #(
	parameter int unsigned QUEUE_DEPTH = u8lit_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,  // transcode_to_utf16
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,      // [7:0] byte_in
	input  logic [1:0] s_tuser,      // [1:0] mode
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,      // [7:0] char_out
	output logic       m_tlast,
	output logic       m_tuser       // [0] error
);

	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_valid;
	u8lit_pkg::job_t q_in_job;
	u8lit_pkg::job_t q_head_job;

	// decoder and classifier
	u8lit_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (q_in_job)
	);

	// job queue
	u8lit_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_in_job),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_job   (q_head_job),
		.full       (q_full)
	);

	// character expander
	u8lit_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head_job   (q_head_job),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

### hw/rtl/u8lit_front.sv
// front end: accepts input beats, runs the utf-8 decoder, classifies into jobs
module u8lit_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // byte_in
	input  logic [1:0]        s_tuser,   // mode
	input  logic              q_full,
	output logic              q_push,
	output u8lit_pkg::job_t   q_job
);

	logic        transcode_q;
	logic [20:0] pcp_q;
	logic [1:0]  brem_q;

	logic [20:0] pcp_d;
	logic [1:0]  brem_d;
	logic        accept;
	logic        keep;
	logic        drop_pend;
	logic [1:0]  eff_brem;
	logic [20:0] cont_pcp;
	logic        overlong;
	logic        bad_cp;
	u8lit_pkg::mode_t mode;
	u8lit_pkg::job_t  job;

	// character pair for two-character escapes and the wide start sequence
	function automatic logic [20:0] pair(input logic [7:0] c0, input logic [7:0] c1);
		return {5'd0, c1, c0};
	endfunction

	// job for a decoded code point
	function automatic u8lit_pkg::job_t cp_job(input logic [20:0] cp);
		u8lit_pkg::job_t j;
		begin
			j = '0;
			if (cp >= 21'h20 && cp < 21'h7f) begin
				j.kind = u8lit_pkg::KIND_CHAR1;
				j.val  = cp;
			end else if (cp < 21'h10000) begin
				j.kind = u8lit_pkg::KIND_HEX1;
				j.val  = cp;
			end else begin
				j.kind = u8lit_pkg::KIND_HEX2;
				j.val  = cp - 21'h10000;
			end
			return j;
		end
	endfunction

	assign mode      = u8lit_pkg::mode_t'(s_tuser);
	assign s_tready  = !q_full;
	assign accept    = s_tvalid && s_tready;
	assign keep      = (mode == u8lit_pkg::MODE_DATA) && transcode_q && (s_tdata[7:6] == 2'b10);
	assign drop_pend = (brem_q != 2'd0) && !keep;
	assign eff_brem  = drop_pend ? 2'd0 : brem_q;
	assign cont_pcp  = {pcp_q[14:0], s_tdata[5:0]};
	assign overlong  = (pcp_q == 21'd0) &&
		(((brem_q == 2'd2) && (s_tdata < 8'ha0)) || ((brem_q == 2'd3) && (s_tdata < 8'h90)));
	assign bad_cp    = ((cont_pcp >= 21'hd800) && (cont_pcp <= 21'hdfff)) || (cont_pcp > 21'h10ffff);

	// classify the beat and work out the next decoder state
	always_comb begin
		u8lit_pkg::job_t cj;
		job    = '0;
		cj     = '0;
		pcp_d  = pcp_q;
		brem_d = brem_q;
		if (mode != u8lit_pkg::MODE_UNUSED && drop_pend) begin
			job.err = 1'b1;
			pcp_d   = '0;
			brem_d  = '0;
		end
		case (mode)
			u8lit_pkg::MODE_START: begin
				if (transcode_q) begin
					job.kind = u8lit_pkg::KIND_CHAR2;
					job.val  = pair(u8lit_pkg::CH_L, u8lit_pkg::CH_QUOTE);
				end else begin
					job.kind = u8lit_pkg::KIND_CHAR1;
					job.val  = {13'd0, u8lit_pkg::CH_QUOTE};
				end
			end
			u8lit_pkg::MODE_END: begin
				job.kind = u8lit_pkg::KIND_CHAR1;
				job.val  = {13'd0, u8lit_pkg::CH_QUOTE};
			end
			u8lit_pkg::MODE_DATA: begin
				if (eff_brem != 2'd0) begin
					// continuation byte of a pending sequence
					if (overlong) begin
						job.err = 1'b1;
						pcp_d   = '0;
						brem_d  = '0;
					end else if (brem_q == 2'd1) begin
						pcp_d  = '0;
						brem_d = '0;
						if (bad_cp) begin
							job.err = 1'b1;
						end else begin
							cj       = cp_job(cont_pcp);
							job.kind = cj.kind;
							job.val  = cj.val;
						end
					end else begin
						pcp_d  = cont_pcp;
						brem_d = brem_q - 2'd1;
					end
				end else begin
					// fresh byte: escapes first, then raw or decode
					case (s_tdata)
						u8lit_pkg::CH_BSLASH: begin
							job.kind = u8lit_pkg::KIND_CHAR2;
							job.val  = pair(u8lit_pkg::CH_BSLASH, u8lit_pkg::CH_BSLASH);
						end
						u8lit_pkg::CH_QUOTE: begin
							job.kind = u8lit_pkg::KIND_CHAR2;
							job.val  = pair(u8lit_pkg::CH_BSLASH, u8lit_pkg::CH_QUOTE);
						end
						u8lit_pkg::CH_LF: begin
							job.kind = u8lit_pkg::KIND_CHAR2;
							job.val  = pair(u8lit_pkg::CH_BSLASH, u8lit_pkg::CH_N);
						end
						u8lit_pkg::CH_CR: begin
							job.kind = u8lit_pkg::KIND_CHAR2;
							job.val  = pair(u8lit_pkg::CH_BSLASH, u8lit_pkg::CH_R);
						end
						default: begin
							if (!transcode_q) begin
								job.kind = u8lit_pkg::KIND_CHAR1;
								job.val  = {13'd0, s_tdata};
							end else if (s_tdata < 8'h80) begin
								cj       = cp_job({13'd0, s_tdata});
								job.kind = cj.kind;
								job.val  = cj.val;
							end else if (s_tdata inside {[8'hc2:8'hdf]}) begin
								brem_d = 2'd1;
								pcp_d  = {16'd0, s_tdata[4:0]};
							end else if (s_tdata inside {[8'he0:8'hef]}) begin
								brem_d = 2'd2;
								pcp_d  = {17'd0, s_tdata[3:0]};
							end else if (s_tdata inside {[8'hf0:8'hf4]}) begin
								brem_d = 2'd3;
								pcp_d  = {18'd0, s_tdata[2:0]};
							end else begin
								job.err = 1'b1;
							end
						end
					endcase
				end
			end
			default: begin
				job    = '0;
				pcp_d  = pcp_q;
				brem_d = brem_q;
			end
		endcase
	end

	assign q_job  = job;
	assign q_push = accept && (job.err || (job.kind != u8lit_pkg::KIND_NONE));

	// decoder state and transcode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transcode_q <= 1'b1;
			pcp_q       <= '0;
			brem_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				transcode_q <= cfg_wr_data;
			end
			if (accept) begin
				pcp_q  <= pcp_d;
				brem_q <= brem_d;
			end
		end
	end

endmodule

### hw/rtl/u8lit_fifo.sv
// job queue between the front end and the back end
`include "assert_macros.svh"
module u8lit_fifo #(
	parameter int unsigned DEPTH = u8lit_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u8lit_pkg::job_t   push_job,
	input  logic              pop,
	output logic              head_valid,
	output u8lit_pkg::job_t   head_job,
	output logic              full
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	u8lit_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign head_valid = (count_q != '0);
	assign full       = (count_q == FULL_CNT);
	assign head_job   = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`ASSERT_IMPLY(a_no_overflow, clk, arst_n, push, !full || pop, "push into full queue")
	`ASSERT_IMPLY(a_no_underflow, clk, arst_n, pop, head_valid, "pop from empty queue")
	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= FULL_CNT, "fill count past depth")

endmodule

### hw/rtl/u8lit_back.sv
// back end: expands queued jobs into output characters, one beat per cycle while the receiver is ready
`include "assert_macros.svh"
module u8lit_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  u8lit_pkg::job_t   head_job,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast,
	output logic              m_tuser
);

	logic        tvalid_q;
	logic [7:0]  tdata_q;
	logic        tlast_q;
	logic        tuser_q;
	logic        err_done_q;
	logic [3:0]  pos_q;

	logic        emit;
	logic        err_now;
	logic [3:0]  nch;
	logic        is_last;
	logic        second;
	logic [2:0]  sub;
	logic [15:0] word;
	logic [15:0] surr_hi;
	logic [15:0] surr_lo;
	logic [7:0]  chr;

	assign emit    = head_valid && (!tvalid_q || m_tready);
	assign err_now = head_job.err && !err_done_q;
	assign nch     = u8lit_pkg::kind_chars(head_job.kind);
	assign is_last = err_now ? (nch == 4'd0) : (pos_q == nch - 4'd1);
	assign pop     = emit && is_last;

	// position inside a hex escape and the 16-bit word it shows
	assign second  = (pos_q >= 4'd6);
	assign sub     = second ? 3'(pos_q - 4'd6) : pos_q[2:0];
	assign surr_hi = u8lit_pkg::SURR_HI | {6'd0, head_job.val[19:10]};
	assign surr_lo = u8lit_pkg::SURR_LO | {6'd0, head_job.val[9:0]};
	assign word    = (head_job.kind == u8lit_pkg::KIND_HEX1) ? head_job.val[15:0] :
		(second ? surr_lo : surr_hi);

	// character at the current position
	always_comb begin
		chr = 8'd0;
		case (head_job.kind)
			u8lit_pkg::KIND_CHAR1: chr = head_job.val[7:0];
			u8lit_pkg::KIND_CHAR2: chr = pos_q[0] ? head_job.val[15:8] : head_job.val[7:0];
			u8lit_pkg::KIND_HEX1, u8lit_pkg::KIND_HEX2: begin
				case (sub)
					3'd0:    chr = u8lit_pkg::CH_BSLASH;
					3'd1:    chr = u8lit_pkg::CH_X;
					3'd2:    chr = u8lit_pkg::hex_char(word[15:12]);
					3'd3:    chr = u8lit_pkg::hex_char(word[11:8]);
					3'd4:    chr = u8lit_pkg::hex_char(word[7:4]);
					default: chr = u8lit_pkg::hex_char(word[3:0]);
				endcase
			end
			default: chr = 8'd0;
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			tdata_q <= err_now ? 8'd0 : chr;
			tlast_q <= is_last;
			tuser_q <= err_now;
		end
	end

	// output valid and sequencing through the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q   <= 1'b0;
			err_done_q <= 1'b0;
			pos_q      <= '0;
		end else begin
			if (emit) begin
				tvalid_q <= 1'b1;
				if (is_last) begin
					err_done_q <= 1'b0;
					pos_q      <= '0;
				end else if (err_now) begin
					err_done_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 4'd1;
				end
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tlast  = tlast_q;
	assign m_tuser  = tuser_q;

	`ASSERT_IMPLY(a_pos_in_range, clk, arst_n, head_valid && !err_now, pos_q < nch, "char position past end of job")
	`ASSERT_IMPLY(a_err_done_job, clk, arst_n, err_done_q, head_valid && head_job.err, "error marked done without error job")
	`ASSERT_IMPLY(a_job_not_empty, clk, arst_n, head_valid, head_job.err || (nch != 4'd0), "queued job emits nothing")

endmodule

### bench/tb_utf8_to_utf16_c_literal_top.sv
// self-checking testbench of the utf-8 path to c string literal encoder
module tb_utf8_to_utf16_c_literal_top;
	import u8lit_pkg::*;

	// one path item waiting to be offered on the slave side
	typedef struct {
		mode_t      md;
		logic [7:0] octet;
	} path_item_t;

	// one literal character expected on the master side
	typedef struct {
		logic [7:0] ch;
		logic       last;
		logic       err;
	} lit_beat_t;

	localparam logic [127:0] HEX_DIGITS = "0123456789abcdef";

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic       cfg_wr_data = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;     // [7:0] byte_in
	logic [1:0] s_tuser = 2'd0;      // [1:0] mode
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;             // [7:0] char_out
	logic       m_tlast;
	logic       m_tuser;             // [0] error

	path_item_t path_q[$];
	lit_beat_t  lit_q[$];
	lit_beat_t  item_chars[$];

	// predictor copy of the register and the decoder state
	logic        wide_mode = 1'b1;
	logic [20:0] dec_cp = 21'd0;
	logic [1:0]  dec_left = 2'd0;

	int   mismatches = 0;
	int   data_count = 0;
	logic steady = 1'b0;
	logic rx_hold = 1'b0;
	logic hold_go = 1'b0;

	utf8_to_utf16_c_literal_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// reset, held low at the start and released on a falling clock edge
	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
	end

	// run limit
	initial begin
		#1000000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what);
		begin
			$display("mismatch at %0t: %s", $time, what);
			mismatches++;
		end
	endtask

	task automatic add_char(input logic [7:0] ch, input logic err);
		lit_beat_t beat;
		begin
			beat.ch = ch;
			beat.last = 1'b0;
			beat.err = err;
			item_chars.push_back(beat);
		end
	endtask

	// backslash, x and four lowercase hex digits
	task automatic add_hex4(input logic [15:0] v);
		int nib;
		begin
			add_char(CH_BSLASH, 1'b0);
			add_char(CH_X, 1'b0);
			for (int i = 3; i >= 0; i--) begin
				nib = int'(v[4*i +: 4]);
				add_char(HEX_DIGITS[8*(15-nib) +: 8], 1'b0);
			end
		end
	endtask

	// printable ascii as is, bmp as one escape, supplementary as a surrogate pair
	task automatic add_code_point(input logic [20:0] cp);
		logic [20:0] off;
		begin
			if (cp >= 21'h20 && cp < 21'h7f) begin
				add_char(cp[7:0], 1'b0);
			end else if (cp < 21'h10000) begin
				add_hex4(cp[15:0]);
			end else begin
				off = cp - 21'h10000;
				add_hex4(SURR_HI | {6'd0, off[19:10]});
				add_hex4(SURR_LO | {6'd0, off[9:0]});
			end
		end
	endtask

	// expected literal characters of one accepted path item
	task automatic encode_path_item(input mode_t md, input logic [7:0] b);
		logic [20:0] cp;
		lit_beat_t   beat;
		begin
			item_chars.delete();
			if (md != MODE_UNUSED) begin
				// a pending sequence is dropped unless a continuation byte follows
				if (dec_left != 2'd0 && !(md == MODE_DATA && wide_mode && b[7:6] == 2'b10)) begin
					dec_cp = 21'd0;
					dec_left = 2'd0;
					add_char(8'h00, 1'b1);
				end
				case (md)
					MODE_START: begin
						if (wide_mode)
							add_char(CH_L, 1'b0);
						add_char(CH_QUOTE, 1'b0);
					end
					MODE_END: begin
						add_char(CH_QUOTE, 1'b0);
					end
					default: begin
						if (dec_left != 2'd0) begin
							// continuation byte, overlong forms caught on the second byte
							if ((dec_left == 2'd2 && dec_cp == 21'd0 && b < 8'ha0) ||
									(dec_left == 2'd3 && dec_cp == 21'd0 && b < 8'h90)) begin
								dec_cp = 21'd0;
								dec_left = 2'd0;
								add_char(8'h00, 1'b1);
							end else begin
								dec_cp = {dec_cp[14:0], b[5:0]};
								dec_left = dec_left - 2'd1;
								if (dec_left == 2'd0) begin
									cp = dec_cp;
									dec_cp = 21'd0;
									if ((cp >= 21'hd800 && cp <= 21'hdfff) || cp > 21'h10ffff)
										add_char(8'h00, 1'b1);
									else
										add_code_point(cp);
								end
							end
						end else if (b == CH_BSLASH) begin
							add_char(CH_BSLASH, 1'b0);
							add_char(CH_BSLASH, 1'b0);
						end else if (b == CH_QUOTE) begin
							add_char(CH_BSLASH, 1'b0);
							add_char(CH_QUOTE, 1'b0);
						end else if (b == CH_LF) begin
							add_char(CH_BSLASH, 1'b0);
							add_char(CH_N, 1'b0);
						end else if (b == CH_CR) begin
							add_char(CH_BSLASH, 1'b0);
							add_char(CH_R, 1'b0);
						end else if (!wide_mode) begin
							add_char(b, 1'b0);
						end else if (b < 8'h80) begin
							add_code_point({13'd0, b});
						end else if (b >= 8'hc2 && b <= 8'hdf) begin
							dec_left = 2'd1;
							dec_cp = {16'd0, b[4:0]};
						end else if (b >= 8'he0 && b <= 8'hef) begin
							dec_left = 2'd2;
							dec_cp = {17'd0, b[3:0]};
						end else if (b >= 8'hf0 && b <= 8'hf4) begin
							dec_left = 2'd3;
							dec_cp = {18'd0, b[2:0]};
						end else begin
							add_char(8'h00, 1'b1);
						end
					end
				endcase
			end
			foreach (item_chars[i]) begin
				beat = item_chars[i];
				beat.last = (i == item_chars.size() - 1);
				lit_q.push_back(beat);
			end
		end
	endtask

	// slave side: predict on each accepted beat, then offer the next item
	always @(posedge clk) begin : path_driver
		path_item_t next_item;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				encode_path_item(mode_t'(s_tuser), s_tdata);
			if (!s_tvalid || s_tready) begin
				if (path_q.size() != 0 && (steady || $urandom_range(99) >= 38)) begin
					next_item = path_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= next_item.md;
					s_tdata <= next_item.octet;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// master side: compare each accepted beat with the oldest expected character
	always @(posedge clk) begin : literal_monitor
		lit_beat_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (lit_q.size() == 0) begin
					report_mismatch($sformatf("unexpected beat char %h last %b err %b",
						m_tdata, m_tlast, m_tuser));
				end else begin
					want = lit_q.pop_front();
					if (m_tdata !== want.ch)
						report_mismatch($sformatf("char %h, want %h", m_tdata, want.ch));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
					if (m_tuser !== want.err)
						report_mismatch($sformatf("error %b, want %b", m_tuser, want.err));
				end
			end
			m_tready <= !rx_hold && (steady || $urandom_range(99) >= 38);
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		wait (hold_go == 1'b1);
		@(negedge clk);
		rx_hold = 1'b1;
		repeat (300) @(negedge clk);
		rx_hold = 1'b0;
	end

	task automatic send(input mode_t md, input logic [7:0] b);
		path_item_t it;
		begin
			it.md = md;
			it.octet = b;
			path_q.push_back(it);
			if (md != MODE_UNUSED)
				data_count++;
		end
	endtask

	// utf-8 bytes of a code point, up to 21 bits
	task automatic send_utf8(input logic [20:0] cp);
		begin
			if (cp < 21'h80) begin
				send(MODE_DATA, cp[7:0]);
			end else if (cp < 21'h800) begin
				send(MODE_DATA, {3'b110, cp[10:6]});
				send(MODE_DATA, {2'b10, cp[5:0]});
			end else if (cp < 21'h10000) begin
				send(MODE_DATA, {4'b1110, cp[15:12]});
				send(MODE_DATA, {2'b10, cp[11:6]});
				send(MODE_DATA, {2'b10, cp[5:0]});
			end else begin
				send(MODE_DATA, {5'b11110, cp[20:18]});
				send(MODE_DATA, {2'b10, cp[17:12]});
				send(MODE_DATA, {2'b10, cp[11:6]});
				send(MODE_DATA, {2'b10, cp[5:0]});
			end
		end
	endtask

	// well-formed literal with random characters
	task automatic send_literal(input int unsigned len);
		logic [20:0] cp;
		begin
			send(MODE_START, 8'($urandom_range(255)));
			repeat (len) begin
				case ($urandom_range(9))
					0, 1, 2, 3: cp = 21'($urandom_range(21'h7e, 21'h20));
					4: begin
						case ($urandom_range(3))
							0: cp = {13'd0, CH_BSLASH};
							1: cp = {13'd0, CH_QUOTE};
							2: cp = {13'd0, CH_LF};
							default: cp = {13'd0, CH_CR};
						endcase
					end
					5: cp = ($urandom_range(1) != 0) ? 21'h7f
						: 21'($urandom_range(21'h1f, 21'h0));
					6: cp = 21'($urandom_range(21'h7ff, 21'h80));
					7: begin
						cp = 21'($urandom_range(21'hffff, 21'h800));
						if (cp >= 21'hd800 && cp <= 21'hdfff)
							cp = cp ^ 21'h2000;
					end
					default: cp = 21'($urandom_range(21'h10ffff, 21'h10000));
				endcase
				send_utf8(cp);
			end
			send(MODE_END, 8'($urandom_range(255)));
		end
	endtask

	// random noise and broken sequences
	task automatic send_noise();
		logic [1:0] m;
		begin
			case ($urandom_range(7))
				0: begin
					m = 2'($urandom_range(3));
					send(mode_t'(m), 8'($urandom_range(255)));
				end
				1: send(MODE_DATA, 8'($urandom_range(255)));
				2: begin
					// truncated sequence cut off by a start, an end or a fresh byte
					send(MODE_DATA, 8'($urandom_range(8'hf4, 8'hc2)));
					if ($urandom_range(1) != 0)
						send(MODE_DATA, {2'b10, 6'($urandom_range(63))});
					m = 2'($urandom_range(2));
					send(mode_t'(m), ($urandom_range(1) != 0) ? 8'($urandom_range(8'h7f, 8'h00))
						: 8'($urandom_range(8'hff, 8'hc0)));
				end
				3: send_utf8(21'($urandom_range(21'hdfff, 21'hd800)));
				4: send_utf8(21'($urandom_range(21'h1fffff, 21'h110000)));
				5: begin
					if ($urandom_range(1) != 0) begin
						send(MODE_DATA, 8'he0);
						send(MODE_DATA, 8'($urandom_range(8'h9f, 8'h80)));
					end else begin
						send(MODE_DATA, 8'hf0);
						send(MODE_DATA, 8'($urandom_range(8'h8f, 8'h80)));
					end
					send(MODE_DATA, 8'h80);
				end
				6: begin
					case ($urandom_range(2))
						0: send(MODE_DATA, 8'($urandom_range(8'hbf, 8'h80)));
						1: send(MODE_DATA, 8'($urandom_range(8'hc1, 8'hc0)));
						default: send(MODE_DATA, 8'($urandom_range(8'hff, 8'hf5)));
					endcase
				end
				default: begin
					// unused mode in the middle of a sequence leaves it pending
					send(MODE_DATA, 8'hc3);
					send(MODE_UNUSED, 8'($urandom_range(255)));
					send(MODE_DATA, 8'ha9);
				end
			endcase
		end
	endtask

	task automatic send_random(input int target);
		begin
			while (data_count < target) begin
				if ($urandom_range(3) != 0)
					send_literal($urandom_range(6));
				else
					send_noise();
			end
		end
	endtask

	// sender pause until every expected character has come
	task automatic wait_drained();
		begin
			while (path_q.size() != 0 || s_tvalid || lit_q.size() != 0)
				@(negedge clk);
		end
	endtask

	// register write while idle, after the pipeline has settled
	task automatic write_transcode(input logic v);
		begin
			wait_drained();
			repeat (8) @(negedge clk);
			@(posedge clk);
			cfg_wr_en <= 1'b1;
			cfg_wr_data <= v;
			wide_mode = v;
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			@(negedge clk);
		end
	endtask

	// stimulus phases
	initial begin
		wait (arst_n == 1'b1);
		@(negedge clk);

		// directed: escapes, extremes and error cases in wide mode
		send(MODE_START, 8'h00);
		send(MODE_DATA, 8'h41);
		send(MODE_DATA, CH_BSLASH);
		send(MODE_DATA, CH_QUOTE);
		send(MODE_DATA, CH_LF);
		send(MODE_DATA, CH_CR);
		send(MODE_DATA, 8'h00);
		send(MODE_DATA, 8'h7f);
		send_utf8(21'h80);
		send_utf8(21'h10ffff);
		send(MODE_DATA, 8'h80);
		send(MODE_DATA, 8'hff);
		send(MODE_DATA, 8'he0);
		send(MODE_DATA, 8'h80);
		send_utf8(21'hd800);
		send(MODE_DATA, 8'hf0);
		send(MODE_DATA, 8'h80);
		send(MODE_DATA, 8'hc3);
		send(MODE_UNUSED, 8'hff);
		send(MODE_END, 8'hff);
		wait_drained();

		// random wide mode with a long receiver hold-off
		hold_go = 1'b1;
		send_random(data_count + 65);
		// leave a sequence pending across the switch to raw mode
		send(MODE_DATA, 8'he2);
		write_transcode(1'b0);

		// raw mode: the pending sequence is dropped by the first byte
		send(MODE_DATA, 8'h80);
		send(MODE_START, 8'h00);
		send(MODE_DATA, CH_BSLASH);
		send(MODE_DATA, 8'hff);
		send(MODE_DATA, 8'h00);
		send(MODE_END, 8'h00);
		send_random(data_count + 28);
		write_transcode(1'b1);

		// wide mode again: no idling first, then a pause, then random idling
		steady = 1'b1;
		send_random(data_count + 20);
		wait_drained();
		steady = 1'b0;
		send_random(data_count + 16);

		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/u8lit_pkg.sv
hw/rtl/u8lit_front.sv
hw/rtl/u8lit_fifo.sv
hw/rtl/u8lit_back.sv
hw/rtl/utf8_to_utf16_c_literal_top.sv
bench/tb_utf8_to_utf16_c_literal_top.sv
